// ===== sv/dns_redirect_responder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// DNS redirect responder assertion macros
// Shared concurrent assertion shorthands for the responder RTL.
// ----------------------------------------------------------------------------
`ifndef DNS_REDIRECT_RESPONDER_UNIT_MACROS_SVH
`define DNS_REDIRECT_RESPONDER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define DNSR_ASSERT_NOW(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("dnsr assertion failed");

// next-cycle implication
`define DNSR_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("dnsr assertion failed");

`else

`define DNSR_ASSERT_NOW(name, clk, rstn, pre, post)
`define DNSR_ASSERT_NEXT(name, clk, rstn, pre, post)

`endif

`endif

// ===== sv/dnsr_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS redirect responder package
// Shared types and constants for the front end, queue and answer back end.
// ----------------------------------------------------------------------------
package dnsr_pkg;

    // request positions saturate at the top of a 10-bit count
    localparam int unsigned POS_W = 10;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;
    localparam logic [POS_W-1:0] NAME_START = 10'd12;

    // header positions that get rewritten
    localparam logic [POS_W-1:0] POS_FLAGS_HI = 10'd2;
    localparam logic [POS_W-1:0] POS_FLAGS_LO = 10'd3;
    localparam logic [POS_W-1:0] POS_ANCOUNT_HI = 10'd6;
    localparam logic [POS_W-1:0] POS_ANCOUNT_LO = 10'd7;

    localparam logic [7:0] FLAGS_HI_BYTE = 8'h81;
    localparam logic [7:0] FLAGS_LO_BYTE = 8'h80;
    localparam logic [7:0] ANCOUNT_HI_BYTE = 8'h00;
    localparam logic [7:0] ANCOUNT_LO_BYTE = 8'h01;

    // answer record
    localparam int unsigned ANSWER_LEN = 16;
    localparam logic [7:0] PTR_HI_BYTE = 8'hC0;
    localparam logic [7:0] PTR_LO_BYTE = 8'h0C;
    localparam logic [7:0] RDLEN_LO_BYTE = 8'h04;

    // frame status codes
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_BAD_NAME = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // register map
    localparam logic REG_REDIRECT_ADDRESS = 1'b0;
    localparam logic REG_ANSWER_TTL = 1'b1;
    localparam logic [31:0] REDIRECT_ADDRESS_RST = 32'h0A00_0101;
    localparam logic [31:0] ANSWER_TTL_RST = 32'd60;

    // one classified request byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
        logic       append;
    } q_entry_t;

    // queue status toward both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // back end status
    typedef struct packed {
        logic answering;
        logic pop;
    } bk_stat_t;

endpackage

// ===== sv/dnsr_front.sv =====
// ----------------------------------------------------------------------------
// DNS redirect responder front end
// Accepts request bytes, rewrites header bytes, walks the question name and
// classifies the final byte of each request.
// ----------------------------------------------------------------------------
module dnsr_front
    import dnsr_pkg::*;
#(
    parameter int unsigned MAX_PACKET = 512,
    parameter int unsigned NAME_LIMIT = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,
    input  q_stat_t    q_stat,
    output logic       q_push,
    output q_entry_t   q_wdata
);

    localparam logic [POS_W-1:0] NAME_MAX = POS_W'(NAME_LIMIT - 1);
    localparam logic [POS_W+1:0] PACKET_MAX = (POS_W+2)'(MAX_PACKET);

    logic [POS_W-1:0] byte_index_reg, byte_index_next;
    logic [POS_W-1:0] label_end_reg, label_end_next;
    logic [8:0]       name_length_reg, name_length_next;
    logic             finished_reg, finished_next;
    logic             bad_name_reg, bad_name_next;

    logic [POS_W-1:0] pos;
    logic [7:0]       echo;
    logic             walk;
    logic [POS_W-1:0] name_sum;
    logic [POS_W:0]   label_sum;
    logic [POS_W:0]   len;
    logic [1:0]       status;
    logic             accept;

    assign s_tready = !q_stat.full;
    assign accept = s_tvalid && s_tready;
    assign q_push = accept;
    assign pos = byte_index_reg;

    // header rewrite
    always_comb begin
        case (pos)
            POS_FLAGS_HI:   echo = FLAGS_HI_BYTE;
            POS_FLAGS_LO:   echo = FLAGS_LO_BYTE;
            POS_ANCOUNT_HI: echo = ANCOUNT_HI_BYTE;
            POS_ANCOUNT_LO: echo = ANCOUNT_LO_BYTE;
            default:        echo = s_tdata;
        endcase
    end

    // name walk and state update
    always_comb begin
        walk = !finished_reg && (pos >= NAME_START) && (pos != POS_MAX)
            && (pos == label_end_reg);
        name_sum = {1'b0, name_length_reg} + {2'b00, s_tdata};
        label_sum = {1'b0, pos} + {3'b000, s_tdata} + (POS_W+1)'(1);

        label_end_next = label_end_reg;
        name_length_next = name_length_reg;
        finished_next = finished_reg;
        bad_name_next = bad_name_reg;

        if (walk) begin
            if (s_tdata == 8'd0) begin
                finished_next = 1'b1;
            end else if (name_sum >= NAME_MAX) begin
                bad_name_next = 1'b1;
                finished_next = 1'b1;
            end else begin
                label_end_next = (label_sum > {1'b0, POS_MAX}) ? POS_MAX
                                                               : label_sum[POS_W-1:0];
                name_length_next = name_length_reg + {1'b0, s_tdata} + 9'd1;
            end
        end

        byte_index_next = (pos == POS_MAX) ? pos : pos + POS_W'(1);

        // final byte classification
        len = {1'b0, pos} + (POS_W+1)'(1);
        if (len < {1'b0, NAME_START}) begin
            status = ST_SHORT;
        end else if (bad_name_next || (!finished_next && ({1'b0, label_end_next} > len))) begin
            status = ST_BAD_NAME;
        end else if (({1'b0, len} + (POS_W+2)'(ANSWER_LEN)) > PACKET_MAX) begin
            status = ST_TOO_LONG;
        end else begin
            status = ST_OK;
        end

        q_wdata.data = echo;
        q_wdata.last = s_tlast && (status != ST_OK);
        q_wdata.status = s_tlast ? status : ST_OK;
        q_wdata.append = s_tlast && (status == ST_OK);
    end

    // frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= '0;
            label_end_reg <= NAME_START;
            name_length_reg <= '0;
            finished_reg <= 1'b0;
            bad_name_reg <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                byte_index_reg <= '0;
                label_end_reg <= NAME_START;
                name_length_reg <= '0;
                finished_reg <= 1'b0;
                bad_name_reg <= 1'b0;
            end else begin
                byte_index_reg <= byte_index_next;
                label_end_reg <= label_end_next;
                name_length_reg <= name_length_next;
                finished_reg <= finished_next;
                bad_name_reg <= bad_name_next;
            end
        end
    end

endmodule

// ===== sv/dnsr_queue.sv =====
// ----------------------------------------------------------------------------
// DNS redirect responder queue
// Four-entry queue of classified bytes between front end and back end.
// ----------------------------------------------------------------------------
module dnsr_queue
    import dnsr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t wdata,
    input  logic     pop,
    output q_entry_t rdata,
    output q_stat_t  stat
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    q_entry_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full = (count_reg == (PTR_W+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push = push && !stat.full;
    assign do_pop = pop && !stat.empty;
    assign rdata = mem_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== sv/dnsr_back.sv =====
// ----------------------------------------------------------------------------
// DNS redirect responder back end
// Drains classified bytes into the output register and appends the
// 16-byte A-record answer after a good request.
// ----------------------------------------------------------------------------
module dnsr_back
    import dnsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] redirect_address,
    input  logic [31:0] answer_ttl,
    input  q_entry_t    q_rdata,
    input  q_stat_t     q_stat,
    output logic        q_pop,
    output bk_stat_t    bk_stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // frame_status[1:0]
);

    localparam int unsigned IDX_W = $clog2(ANSWER_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ANSWER_LEN - 1);

    logic             answering_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic             m_tlast_reg;
    logic [1:0]       m_tuser_reg;
    logic             load;
    logic [7:0]       answer_byte;

    assign load = !m_tvalid_reg || m_tready;
    assign q_pop = load && !answering_reg && !q_stat.empty;
    assign bk_stat.answering = answering_reg;
    assign bk_stat.pop = q_pop;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;
    assign m_tuser = m_tuser_reg;

    // answer record bytes
    always_comb begin
        case (idx_reg)
            4'd0:    answer_byte = PTR_HI_BYTE;
            4'd1:    answer_byte = PTR_LO_BYTE;
            4'd2:    answer_byte = 8'h00;
            4'd3:    answer_byte = 8'h01;
            4'd4:    answer_byte = 8'h00;
            4'd5:    answer_byte = 8'h01;
            4'd6:    answer_byte = answer_ttl[31:24];
            4'd7:    answer_byte = answer_ttl[23:16];
            4'd8:    answer_byte = answer_ttl[15:8];
            4'd9:    answer_byte = answer_ttl[7:0];
            4'd10:   answer_byte = 8'h00;
            4'd11:   answer_byte = RDLEN_LO_BYTE;
            4'd12:   answer_byte = redirect_address[31:24];
            4'd13:   answer_byte = redirect_address[23:16];
            4'd14:   answer_byte = redirect_address[15:8];
            default: answer_byte = redirect_address[7:0];
        endcase
    end

    // answer sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            answering_reg <= 1'b0;
            idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (load) begin
            if (answering_reg) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg <= answer_byte;
                m_tlast_reg <= (idx_reg == IDX_LAST);
                m_tuser_reg <= ST_OK;
                idx_reg <= idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST) begin
                    answering_reg <= 1'b0;
                end
            end else if (!q_stat.empty) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg <= q_rdata.data;
                m_tlast_reg <= q_rdata.last;
                m_tuser_reg <= q_rdata.status;
                if (q_rdata.append) begin
                    answering_reg <= 1'b1;
                    idx_reg <= '0;
                end
            end else begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/dns_redirect_responder_unit.sv =====
// ----------------------------------------------------------------------------
// DNS redirect responder
// Echoes a DNS request byte stream as a response and appends an A-record
// answer carrying the configured address and TTL.
//
//   channel   dir  handshake          payload
//   s_        in   tvalid/tready      tdata = in_byte, tlast = in_last
//   m_        out  tvalid/tready      tdata = out_byte, tlast = out_last,
//                                     tuser = frame_status
//   apb       in   psel/penable       redirect_address @0, answer_ttl @4
//
// One request byte is taken per cycle while s_tready is high; each response byte
// passes the queue and the output register, one word per cycle while m_tready is high.
// A good request adds 16 answer words, so the output port sets the pace:
// the four-entry queue fills and s_tready drops during the answer.
// Reset is synchronous on aresetn and restores both registers.
// ----------------------------------------------------------------------------
`include "dns_redirect_responder_unit_macros.svh"

module dns_redirect_responder_unit
    import dnsr_pkg::*;
#(
    parameter int unsigned MAX_PACKET = 512,
    parameter int unsigned NAME_LIMIT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // frame_status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] redirect_address_reg;
    logic [31:0] answer_ttl_reg;
    logic        cfg_write;
    q_entry_t    q_wdata;
    q_entry_t    q_rdata;
    q_stat_t     q_stat;
    logic        q_push;
    logic        q_pop;
    bk_stat_t    bk_stat;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ANSWER_TTL) ? answer_ttl_reg : redirect_address_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            redirect_address_reg <= REDIRECT_ADDRESS_RST;
            answer_ttl_reg <= ANSWER_TTL_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_REDIRECT_ADDRESS) begin
                redirect_address_reg <= pwdata;
            end else begin
                answer_ttl_reg <= pwdata;
            end
        end
    end

    dnsr_front #(
        .MAX_PACKET(MAX_PACKET),
        .NAME_LIMIT(NAME_LIMIT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    dnsr_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .stat   (q_stat)
    );

    dnsr_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .redirect_address(redirect_address_reg),
        .answer_ttl      (answer_ttl_reg),
        .q_rdata         (q_rdata),
        .q_stat          (q_stat),
        .q_pop           (q_pop),
        .bk_stat         (bk_stat),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser)
    );

    // status only travels with the final word
    `DNSR_ASSERT_NOW(a_status_on_last, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tlast)
    // a full queue holds off the input
    `DNSR_ASSERT_NOW(a_full_stalls, aclk, aresetn, q_stat.full, !s_tready)
    // no queue pop while the answer is being sent
    `DNSR_ASSERT_NOW(a_no_pop_in_answer, aclk, aresetn, bk_stat.answering, !bk_stat.pop)
    // a good final echo word is always followed by the answer
    `DNSR_ASSERT_NEXT(a_answer_follows, aclk, aresetn,
        bk_stat.pop && q_rdata.append, bk_stat.answering)

endmodule

// ===== tb/sv/tb_dns_redirect_responder_unit.sv =====
// ----------------------------------------------------------------------------
// DNS redirect responder testbench
// Sends DNS requests one word at a time and checks every response word
// against a local model of the echo, header rewrite, question-name walk and
// answer append. Directed requests cover the header rewrite, short requests,
// name boundaries and register extremes. Random traffic follows, mostly
// well-formed queries with some noise and broken names.
// Both sides idle at random, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_dns_redirect_responder_unit;
    import dnsr_pkg::*;

    localparam int unsigned PACKET_LIMIT = 512;
    localparam int unsigned NAME_CHAR_LIMIT = 256;
    localparam int unsigned HEADER_LEN = 12;
    localparam int unsigned RANDOM_BYTES = 40;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT = 50000;
    localparam logic [15:0] RR_TYPE_A = 16'h0001;
    localparam logic [15:0] RR_CLASS_IN = 16'h0001;

    // one response word as seen on the m_ side
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } resp_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // in_byte[7:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte[7:0]
    logic        m_tlast;
    logic [1:0]  m_tuser;   // frame_status[1:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // model state
    int unsigned req_pos;
    int unsigned next_label;
    int unsigned name_chars;
    bit          name_done;
    bit          name_bad;
    logic [31:0] cfg_address;
    logic [31:0] cfg_ttl;

    resp_word_t  expected_words[$];
    logic [7:0]  req_bytes[$];
    int unsigned mismatch_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned rx_stall_left = 0;

    dns_redirect_responder_unit #(
        .MAX_PACKET(PACKET_LIMIT),
        .NAME_LIMIT(NAME_CHAR_LIMIT)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic void report_mismatch(string what, logic [31:0] exp_val,
                                            logic [31:0] act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0h, got %0h", what, exp_val, act_val);
    endfunction

    // ------------------------------------------------------------------
    // response model
    // ------------------------------------------------------------------
    function automatic void clear_request_state();
        req_pos = 0;
        next_label = NAME_START;
        name_chars = 0;
        name_done = 1'b0;
        name_bad = 1'b0;
    endfunction

    function automatic void queue_word(logic [7:0] data, logic last, logic [1:0] status);
        resp_word_t w;
        w.data = data;
        w.last = last;
        w.status = status;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_response(logic [7:0] b, logic last);
        logic [7:0]  echo;
        logic [1:0]  status;
        int unsigned req_len;
        int unsigned label_stop;
        echo = b;
        // header rewrite
        if (req_pos == POS_FLAGS_HI)
            echo = FLAGS_HI_BYTE;
        else if (req_pos == POS_FLAGS_LO)
            echo = FLAGS_LO_BYTE;
        else if (req_pos == POS_ANCOUNT_HI)
            echo = ANCOUNT_HI_BYTE;
        else if (req_pos == POS_ANCOUNT_LO)
            echo = ANCOUNT_LO_BYTE;

        // walk the question name one label length at a time
        if (!name_done && req_pos >= NAME_START && req_pos < POS_MAX
                && req_pos == next_label) begin
            if (b == 8'h00) begin
                name_done = 1'b1;
            end else if (name_chars + b >= NAME_CHAR_LIMIT - 1) begin
                name_bad = 1'b1;
                name_done = 1'b1;
            end else begin
                label_stop = req_pos + 1 + b;
                next_label = (label_stop > POS_MAX) ? POS_MAX : label_stop;
                name_chars += b + 1;
            end
        end

        if (!last) begin
            queue_word(echo, 1'b0, ST_OK);
            if (req_pos < POS_MAX)
                req_pos++;
            return;
        end

        req_len = req_pos + 1;
        if (req_len < NAME_START)
            status = ST_SHORT;
        else if (name_bad || (!name_done && next_label > req_len))
            status = ST_BAD_NAME;
        else if (req_len + ANSWER_LEN > PACKET_LIMIT)
            status = ST_TOO_LONG;
        else
            status = ST_OK;

        if (status != ST_OK) begin
            queue_word(echo, 1'b1, status);
        end else begin
            // echo, then the A record answer
            queue_word(echo, 1'b0, ST_OK);
            queue_word(PTR_HI_BYTE, 1'b0, ST_OK);
            queue_word(PTR_LO_BYTE, 1'b0, ST_OK);
            queue_word(RR_TYPE_A[15:8], 1'b0, ST_OK);
            queue_word(RR_TYPE_A[7:0], 1'b0, ST_OK);
            queue_word(RR_CLASS_IN[15:8], 1'b0, ST_OK);
            queue_word(RR_CLASS_IN[7:0], 1'b0, ST_OK);
            queue_word(cfg_ttl[31:24], 1'b0, ST_OK);
            queue_word(cfg_ttl[23:16], 1'b0, ST_OK);
            queue_word(cfg_ttl[15:8], 1'b0, ST_OK);
            queue_word(cfg_ttl[7:0], 1'b0, ST_OK);
            queue_word(8'h00, 1'b0, ST_OK);
            queue_word(RDLEN_LO_BYTE, 1'b0, ST_OK);
            queue_word(cfg_address[31:24], 1'b0, ST_OK);
            queue_word(cfg_address[23:16], 1'b0, ST_OK);
            queue_word(cfg_address[15:8], 1'b0, ST_OK);
            queue_word(cfg_address[7:0], 1'b1, ST_OK);
        end
        clear_request_state();
    endfunction

    // ------------------------------------------------------------------
    // response checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        resp_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 32'h0, {23'h0, m_tlast, m_tdata});
            end else begin
                want = expected_words.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch("out_byte", want.data, m_tdata);
                if (m_tlast !== want.last)
                    report_mismatch("out_last", want.last, m_tlast);
                if (m_tuser !== want.status)
                    report_mismatch("frame_status", want.status, m_tuser);
            end
        end
    end

    // output side: random idling plus requested hold-offs
    always @(negedge aclk) begin
        if (rx_stall_left == 0 && $urandom_range(0, 99) < rx_idle_pct)
            rx_stall_left = idle_len();
        if (rx_stall_left > 0) begin
            m_tready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_response(data, last);
    endtask

    task automatic send_request();
        for (int i = 0; i < req_bytes.size(); i++)
            send_word(req_bytes[i], i == req_bytes.size() - 1);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // every request word causes a response word, so empty means idle
    task automatic wait_until_idle();
        stop_sending();
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [31:0] value);
        wait_until_idle();
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (reg_sel == REG_REDIRECT_ADDRESS)
            cfg_address = value;
        else
            cfg_ttl = value;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------
    function automatic void begin_request();
        req_bytes.delete();
        repeat (HEADER_LEN) req_bytes.push_back(rand_byte());
    endfunction

    function automatic void add_fill(int unsigned n);
        repeat (n) req_bytes.push_back(rand_byte());
    endfunction

    function automatic void add_label(int unsigned len);
        req_bytes.push_back(8'(len));
        add_fill(len);
    endfunction

    // header and an empty name only
    function automatic void build_minimal_query();
        begin_request();
        req_bytes.push_back(8'h00);
    endfunction

    // query with a few random labels, terminator, type and class
    function automatic void build_query();
        int unsigned labels;
        begin_request();
        labels = $urandom_range(0, 4);
        repeat (labels) begin
            if ($urandom_range(0, 7) == 0)
                add_label($urandom_range(1, 63));
            else
                add_label($urandom_range(1, 10));
        end
        req_bytes.push_back(8'h00);
        add_fill(4);
        if ($urandom_range(0, 3) == 0)
            add_fill($urandom_range(0, 6));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_answer_format();
        // header all ones, then all zeros, so the rewrite shows on every bit
        for (int pass = 0; pass < 2; pass++) begin
            req_bytes.delete();
            repeat (HEADER_LEN) req_bytes.push_back(pass == 0 ? 8'hFF : 8'h00);
            add_label(3);
            add_label(3);
            req_bytes.push_back(8'h00);
            add_fill(4);
            send_request();
        end
    endtask

    task automatic test_short_requests();
        // single word, one below a full header, exactly a header
        req_bytes.delete();
        req_bytes.push_back(8'hFF);
        send_request();
        begin_request();
        void'(req_bytes.pop_back());
        send_request();
        begin_request();
        send_request();
    endtask

    task automatic test_name_boundaries();
        // unterminated name that ends exactly at the last word
        begin_request();
        add_label(3);
        send_request();
        // label runs past the end of the request
        begin_request();
        add_label(5);
        void'(req_bytes.pop_back());
        void'(req_bytes.pop_back());
        void'(req_bytes.pop_back());
        send_request();
        // a single label length that alone breaks the name limit
        begin_request();
        req_bytes.push_back(8'(NAME_CHAR_LIMIT - 1));
        add_fill(4);
        send_request();
    endtask

    task automatic test_register_extremes();
        write_register(REG_REDIRECT_ADDRESS, 32'h0000_0000);
        write_register(REG_ANSWER_TTL, 32'hFFFF_FFFF);
        build_minimal_query();
        send_request();
        write_register(REG_REDIRECT_ADDRESS, 32'hFFFF_FFFF);
        write_register(REG_ANSWER_TTL, 32'h0000_0000);
        build_minimal_query();
        send_request();
    endtask

    task automatic test_output_hold_off();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_stall_left = 400;
        repeat (2) begin
            build_minimal_query();
            send_request();
        end
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    write_register(REG_REDIRECT_ADDRESS, $urandom);
                else
                    write_register(REG_ANSWER_TTL, $urandom);
            end
            case ($urandom_range(0, 2))
                0: tx_idle_pct = 0;
                1: tx_idle_pct = 15;
                default: tx_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: rx_idle_pct = 0;
                1: rx_idle_pct = 15;
                default: rx_idle_pct = 40;
            endcase
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                build_query();
            end else if (kind == 7) begin
                // noise of random length
                req_bytes.delete();
                add_fill($urandom_range(1, 30));
            end else if (kind == 8) begin
                // name cut off inside a label
                begin_request();
                len = $urandom_range(3, 20);
                req_bytes.push_back(8'(len));
                add_fill($urandom_range(0, len - 1));
            end else begin
                // unterminated name ending on the last word
                begin_request();
                repeat ($urandom_range(1, 3)) add_label($urandom_range(1, 8));
            end
            sent += req_bytes.size();
            send_request();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned waited;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_address = REDIRECT_ADDRESS_RST;
        cfg_ttl = ANSWER_TTL_RST;
        clear_request_state();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 20;
        rx_idle_pct = 20;
        test_answer_format();
        test_short_requests();
        test_name_boundaries();
        test_register_extremes();
        test_output_hold_off();
        test_random_traffic();

        // drain, then watch for stray words
        stop_sending();
        waited = 0;
        while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (expected_words.size() != 0)
            report_mismatch("words never sent", expected_words.size(), 32'h0);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
